/* sv/source_address_learning_table_macros.svh */
// Assertion macros for the source address learning table checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SOURCE_ADDRESS_LEARNING_TABLE_MACROS_SVH
`define SOURCE_ADDRESS_LEARNING_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sal_pkg.sv */
// Shared types and constants of the source address learning table.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
`default_nettype none

package sal_pkg;

  localparam int DEF_TABLE_ENTRIES   = 64;
  localparam int DEF_SWITCH_ID_WIDTH = 8;

  localparam int SWITCH_ID_W     = 8;
  localparam int MAC_W           = 48;
  localparam int IP_W            = 64;
  localparam int IPV4_W          = 32;
  localparam int PORT_W          = 32;
  localparam int OUTCOME_W       = 3;
  localparam int ENTRY_INDEX_W   = 6;
  localparam int CLEARED_COUNT_W = 7;

  localparam logic MODE_LEARN  = 1'b0;
  localparam logic MODE_FORGET = 1'b1;
  localparam logic FAM_IPV4    = 1'b0;
  localparam logic FAM_IPV6    = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_INSERTED = 3'd0,
    OUT_UPDATED  = 3'd1,
    OUT_FULL     = 3'd2,
    OUT_SKIPPED  = 3'd3,
    OUT_CLEARED  = 3'd4
  } outcome_t;

  // lookup key broadcast to every cell (switch id travels separately)
  typedef struct packed {
    logic             forget;
    logic             fam;
    logic [MAC_W-1:0] mac;
  } sal_key_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic active;
    logic hit;
    logic free;
  } sal_tok_t;

  // slot write broadcast at the end of a learn search
  typedef struct packed {
    logic              en;
    logic              insert;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } sal_wr_t;

endpackage

`default_nettype wire

/* sv/sal_if.sv */
// Valid/ready channel interfaces for learn items and result items.
// Depends on sal_pkg for field widths.
`default_nettype none

interface sal_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [sal_pkg::SWITCH_ID_W-1:0]  switch_id;
  logic                             is_ipv6;
  logic [sal_pkg::MAC_W-1:0]        src_mac;
  logic [sal_pkg::IP_W-1:0]         src_ip;
  logic [sal_pkg::PORT_W-1:0]       in_port;
  logic                             port_valid;

  modport source (output valid, mode, switch_id, is_ipv6, src_mac, src_ip, in_port,
                  port_valid, input ready);
  modport sink   (input valid, mode, switch_id, is_ipv6, src_mac, src_ip, in_port,
                  port_valid, output ready);
endinterface

interface sal_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [sal_pkg::OUTCOME_W-1:0]        outcome;
  logic [sal_pkg::ENTRY_INDEX_W-1:0]    entry_index;
  logic [sal_pkg::CLEARED_COUNT_W-1:0]  cleared_count;

  modport source (output valid, outcome, entry_index, cleared_count, input ready);
  modport sink   (input valid, outcome, entry_index, cleared_count, output ready);
endinterface

`default_nettype wire

/* sv/sal_cell.sv */
// One table slot: stored entry, local key compare and one stage of the search chain.
// Depends on sal_pkg.
`default_nettype none

module sal_cell #(
  parameter int               IDX_W = 6,
  parameter int               CNT_W = 7,
  parameter int               SW_W  = 8,
  parameter logic [IDX_W-1:0] INDEX = '0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sal_pkg::sal_key_t             key_i,
  input  wire logic [SW_W-1:0]               sw_i,
  input  wire sal_pkg::sal_tok_t             tok_i,
  input  wire logic [IDX_W-1:0]              idx_i,
  input  wire logic [CNT_W-1:0]              cnt_i,
  output sal_pkg::sal_tok_t                  tok_o,
  output logic [IDX_W-1:0]                   idx_o,
  output logic [CNT_W-1:0]                   cnt_o,
  input  wire sal_pkg::sal_wr_t              wr_i,
  input  wire logic [IDX_W-1:0]              wr_idx_i
);

  logic                           valid_r;
  logic [SW_W-1:0]                sw_r;
  logic                           fam_r;
  logic [sal_pkg::MAC_W-1:0]      mac_r;
  logic [sal_pkg::IP_W-1:0]       ip_r;
  logic [sal_pkg::PORT_W-1:0]     port_r;

  sal_pkg::sal_tok_t              tok_r, tok_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;

  logic match_sw, match_key, clr, wr_sel;

  assign match_sw  = valid_r && (sw_r == sw_i);
  assign match_key = match_sw && (fam_r == key_i.fam) && (mac_r == key_i.mac);
  assign wr_sel    = wr_i.en && (wr_idx_i == INDEX);

  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    cnt_nxt = cnt_i;
    clr     = 1'b0;
    if (tok_i.active) begin
      if (key_i.forget) begin
        if (match_sw) begin
          clr     = 1'b1;
          cnt_nxt = cnt_i + 1'b1;
        end
      end else if (!tok_i.hit && match_key) begin
        // a hit overrides any free slot seen earlier
        tok_nxt.hit = 1'b1;
        idx_nxt     = INDEX;
      end else if (!tok_i.hit && !tok_i.free && !valid_r) begin
        tok_nxt.free = 1'b1;
        idx_nxt      = INDEX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_nxt.active;
    end
    tok_r.hit  <= tok_nxt.hit;
    tok_r.free <= tok_nxt.free;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (wr_sel && wr_i.insert) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      if (wr_i.insert) begin
        sw_r  <= sw_i;
        fam_r <= key_i.fam;
        mac_r <= key_i.mac;
      end
      ip_r   <= wr_i.ip;
      port_r <= wr_i.port;
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;
  assign cnt_o = cnt_r;

endmodule

`default_nettype wire

/* sv/source_address_learning_table.sv */
// Source address learning table: TABLE_ENTRIES slots in a chain of sal_cell stages.
// One transaction in flight: a new item is taken only after the previous result has moved
// to the output register; the search token walks one cell per cycle down the chain.
// A pending result may wait in the output register while the next item is accepted.
// Synchronous active-low reset empties every slot and the result register.
// Depends on sal_pkg, sal_if and sal_cell.
`default_nettype none

module source_address_learning_table #(
  parameter int TABLE_ENTRIES   = sal_pkg::DEF_TABLE_ENTRIES,
  parameter int SWITCH_ID_WIDTH = sal_pkg::DEF_SWITCH_ID_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sal_in_if.sink    in_chan,
  sal_out_if.source out_chan
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SW_W  = SWITCH_ID_WIDTH;
  localparam int EI_W  = sal_pkg::ENTRY_INDEX_W;
  localparam int CC_W  = sal_pkg::CLEARED_COUNT_W;

  // item registers
  sal_pkg::sal_key_t              key_r;
  logic [SW_W-1:0]                sw_r;
  logic [sal_pkg::IP_W-1:0]       ip_r;
  logic [sal_pkg::PORT_W-1:0]     port_r;
  logic                           pvalid_r;

  logic                           busy_r;
  logic                           start_r;
  logic                           done_r;
  sal_pkg::sal_tok_t              done_tok_r;
  logic [IDX_W-1:0]               done_idx_r;
  logic [CNT_W-1:0]               done_cnt_r;

  logic                           out_valid_r;
  logic [sal_pkg::OUTCOME_W-1:0]  outcome_r;
  logic [EI_W-1:0]                entry_r;
  logic [CC_W-1:0]                count_r;

  sal_pkg::sal_tok_t              tok_chain [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]               idx_chain [TABLE_ENTRIES+1];
  logic [CNT_W-1:0]               cnt_chain [TABLE_ENTRIES+1];

  logic                           accept, fire;
  logic [SW_W+sal_pkg::SWITCH_ID_W-1:0] sw_ext;
  logic [IDX_W+EI_W-1:0]          idx_ext;
  logic [CNT_W+CC_W-1:0]          cnt_ext;
  sal_pkg::outcome_t              outcome_nxt;
  logic                           show_idx;
  sal_pkg::sal_wr_t               wr;

  assign in_chan.ready = !busy_r;
  assign accept        = in_chan.valid && !busy_r;
  assign fire          = done_r && (!out_valid_r || out_chan.ready);
  assign sw_ext        = {{SW_W{1'b0}}, in_chan.switch_id};

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r.forget <= (in_chan.mode == sal_pkg::MODE_FORGET);
      key_r.fam    <= in_chan.is_ipv6;
      key_r.mac    <= in_chan.src_mac;
      sw_r         <= sw_ext[SW_W-1:0];
      ip_r         <= (in_chan.is_ipv6 == sal_pkg::FAM_IPV6) ? in_chan.src_ip :
                      {{(sal_pkg::IP_W-sal_pkg::IPV4_W){1'b0}},
                       in_chan.src_ip[sal_pkg::IPV4_W-1:0]};
      port_r       <= in_chan.in_port;
      pvalid_r     <= in_chan.port_valid;
    end
  end

  assign tok_chain[0] = '{active: start_r, hit: 1'b0, free: 1'b0};
  assign idx_chain[0] = '0;
  assign cnt_chain[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    sal_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .SW_W  (SW_W),
      .INDEX (IDX_W'(i))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key_i    (key_r),
      .sw_i     (sw_r),
      .tok_i    (tok_chain[i]),
      .idx_i    (idx_chain[i]),
      .cnt_i    (cnt_chain[i]),
      .tok_o    (tok_chain[i+1]),
      .idx_o    (idx_chain[i+1]),
      .cnt_o    (cnt_chain[i+1]),
      .wr_i     (wr),
      .wr_idx_i (done_idx_r)
    );
  end

  // slot write goes out when the result moves to the output register
  always_comb begin
    wr.en     = fire && !key_r.forget && pvalid_r && (done_tok_r.hit || done_tok_r.free);
    wr.insert = !done_tok_r.hit;
    wr.ip     = ip_r;
    wr.port   = port_r;
  end

  always_comb begin
    show_idx = 1'b0;
    if (key_r.forget) begin
      outcome_nxt = sal_pkg::OUT_CLEARED;
    end else if (!pvalid_r) begin
      outcome_nxt = sal_pkg::OUT_SKIPPED;
    end else if (done_tok_r.hit) begin
      outcome_nxt = sal_pkg::OUT_UPDATED;
      show_idx    = 1'b1;
    end else if (done_tok_r.free) begin
      outcome_nxt = sal_pkg::OUT_INSERTED;
      show_idx    = 1'b1;
    end else begin
      outcome_nxt = sal_pkg::OUT_FULL;
    end
  end

  assign idx_ext = {{EI_W{1'b0}}, (show_idx ? done_idx_r : {IDX_W{1'b0}})};
  assign cnt_ext = {{CC_W{1'b0}}, (key_r.forget ? done_cnt_r : {CNT_W{1'b0}})};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (tok_chain[TABLE_ENTRIES].active) begin
        done_r <= 1'b1;
      end else if (fire) begin
        done_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_chain[TABLE_ENTRIES].active) begin
      done_tok_r <= tok_chain[TABLE_ENTRIES];
      done_idx_r <= idx_chain[TABLE_ENTRIES];
      done_cnt_r <= cnt_chain[TABLE_ENTRIES];
    end
    if (fire) begin
      outcome_r <= outcome_nxt;
      entry_r   <= idx_ext[EI_W-1:0];
      count_r   <= cnt_ext[CC_W-1:0];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.outcome       = outcome_r;
  assign out_chan.entry_index   = entry_r;
  assign out_chan.cleared_count = count_r;

endmodule

`default_nettype wire

/* sv/sal_checker.sv */
// Port-level checker for the source address learning table, bound to the top level.
// Depends on sal_pkg and source_address_learning_table_macros.svh.
`default_nettype none
`include "source_address_learning_table_macros.svh"

module sal_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [sal_pkg::OUTCOME_W-1:0]        outcome,
  input wire logic [sal_pkg::ENTRY_INDEX_W-1:0]    entry_index,
  input wire logic [sal_pkg::CLEARED_COUNT_W-1:0]  cleared_count
);

  logic no_slot, not_forget;

  assign no_slot    = (outcome != sal_pkg::OUT_INSERTED) && (outcome != sal_pkg::OUT_UPDATED);
  assign not_forget = (outcome != sal_pkg::OUT_CLEARED);

  `SAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SAL_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready, "second transaction taken in flight")
  `SAL_ASSERT_NOW(a_outcome_range, out_valid, outcome <= sal_pkg::OUT_CLEARED, "bad outcome code")
  `SAL_ASSERT_NOW(a_idx_zero, out_valid && no_slot, entry_index == '0, "stray entry index")
  `SAL_ASSERT_NOW(a_cnt_zero, out_valid && not_forget, cleared_count == '0, "stray clear count")

endmodule

bind source_address_learning_table sal_checker u_sal_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .outcome       (out_chan.outcome),
  .entry_index   (out_chan.entry_index),
  .cleared_count (out_chan.cleared_count)
);

`default_nettype wire
